// ===== sv/text_console_writer_unit_assert.svh =====
// Assertion macros for the text console writer checker.
// Included by the checker file; depends on nothing else.
`ifndef TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH

// Condition implies property in the same cycle; off while reset is high.
`define TCW_ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("text console writer: same-cycle check failed");

// Condition implies property in the next cycle; off while reset is high.
`define TCW_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("text console writer: next-cycle check failed");

`endif

// ===== sv/tcw_pkg.sv =====
// Shared constants, types and codes of the text console writer.
// Used by every other file of the block but the RAM and the assertion macros header; depends on nothing.
package tcw_pkg;

   // Screen geometry.
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = ROWS * COLUMNS;

   // Internal widths follow from the geometry.
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ADDR_W = $clog2(CELL_COUNT);

   // Field widths of the channels.
   localparam int ACTION_W = 2;
   localparam int CHAR_W   = 8;
   localparam int COLOR_W  = 8;
   localparam int TROW_W   = 5;
   localparam int TCOL_W   = 7;
   localparam int POS_W    = 11;
   localparam int CELL_W   = 16;

   // Depth of the command queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Action codes.
   localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_SET   = 2'd3;

   // Character and attribute constants.
   localparam logic [CHAR_W-1:0]  NEWLINE_CODE     = 8'h0A;
   localparam logic [CHAR_W-1:0]  SPACE_CODE       = 8'h20;
   localparam logic [COLOR_W-1:0] BLANK_ATTR_RESET = 8'h0F;

   typedef logic [ROW_W-1:0]   row_type;
   typedef logic [COL_W-1:0]   col_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [CELL_W-1:0]  cell_type;
   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [COLOR_W-1:0] color_type;

   // A classified command, target already saturated to the screen.
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                newline;
      char_type            code;
      color_type           color;
      row_type             row;
      col_type             col;
   } cmd_type;

   // Front to queue.
   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } push_type;

   // Queue head seen by the back.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

endpackage

// ===== sv/tcw_req_if.sv =====
// Request channel of the text console writer: handshake and request fields.
// Depends on tcw_pkg for the field widths.
interface tcw_req_if;
   logic                          valid;
   logic                          ready;
   logic [tcw_pkg::ACTION_W-1:0]  action;
   logic [tcw_pkg::CHAR_W-1:0]    char_code;
   logic [tcw_pkg::COLOR_W-1:0]   char_color;
   logic [tcw_pkg::TROW_W-1:0]    target_row;
   logic [tcw_pkg::TCOL_W-1:0]    target_col;

   modport source (output valid, action, char_code, char_color, target_row, target_col,
                   input ready);
   modport sink (input valid, action, char_code, char_color, target_row, target_col,
                 output ready);
endinterface

// ===== sv/tcw_rsp_if.sv =====
// Response channel of the text console writer: handshake and result fields.
// Depends on tcw_pkg for the field widths.
interface tcw_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tcw_pkg::POS_W-1:0]   cursor_position;
   logic [tcw_pkg::TROW_W-1:0]  cursor_row;
   logic [tcw_pkg::TCOL_W-1:0]  cursor_col;
   logic [tcw_pkg::CELL_W-1:0]  cell_value;

   modport source (output valid, cursor_position, cursor_row, cursor_col, cell_value,
                   input ready);
   modport sink (input valid, cursor_position, cursor_row, cursor_col, cell_value,
                 output ready);
endinterface

// ===== sv/text_console_writer_unit.sv =====
// Top level of the text console writer: blank attribute register, front, queue, back.
// Depends on tcw_pkg, tcw_req_if, tcw_rsp_if, tcw_front, tcw_queue and tcw_back.
//
// Use: each request on req_bus carries an action (put character, clear screen,
// read cell, set cursor) and yields exactly one response on rsp_bus with the
// cursor after the action and, for a read, the cell; other actions return 0.
// The blank attribute, which colors cells blanked by scroll and clear, is written
// through csr_write_enable / csr_write_data; the user is to write it only while the
// block is idle, a rule the block itself leaves unchecked.
// Path: an accepted request enters the queue and is popped in ST_IDLE, run in ST_EXEC
// and answered from ST_DONE into the response register; a read also passes ST_READ,
// a scroll sweeps a row of COLUMNS cells (80) and a clear all ROWS*COLUMNS cells
// (2000) in ST_SWEEP. The back sequencer pops, executes and answers one command at a
// time through the single write and single read port of the cell store.
// Reset: the back blanks all 2000 cells with attribute 0x0F, one cell a
// cycle; req_bus.ready stays low during that sweep, CSR writes are taken.
// Stall: a response waits in its register while rsp_bus.ready is low; the
// back then holds its next finished command and the two-entry queue keeps
// taking requests until it fills.
module text_console_writer_unit (
   input  logic                          clock,
   input  logic                          reset,
   tcw_req_if.sink                       req_bus,
   tcw_rsp_if.source                     rsp_bus,
   input  logic                          csr_write_enable,
   input  logic [tcw_pkg::COLOR_W-1:0]   csr_write_data
);

   logic [tcw_pkg::COLOR_W-1:0] blank_attr_ff, blank_attr_in;
   tcw_pkg::push_type           push;
   tcw_pkg::head_type           head;
   logic                        queue_full;
   logic                        pop;
   logic                        init_busy;

   // Blank attribute register.
   assign blank_attr_in = csr_write_enable ? csr_write_data : blank_attr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blank_attr_ff <= tcw_pkg::BLANK_ATTR_RESET;
      end else begin
         blank_attr_ff <= blank_attr_in;
      end
   end

   tcw_front u_front (
      .req_bus       (req_bus),
      .accept_enable (!init_busy),
      .queue_full    (queue_full),
      .push_out      (push)
   );

   tcw_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .full    (queue_full),
      .head    (head),
      .pop     (pop)
   );

   tcw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .blank_attr (blank_attr_ff),
      .head       (head),
      .pop        (pop),
      .init_busy  (init_busy),
      .rsp_bus    (rsp_bus)
   );

endmodule

// ===== sv/tcw_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the cell store of the console.
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/tcw_front.sv =====
// Front of the console: takes requests, saturates the target and classifies them.
// Depends on tcw_pkg and tcw_req_if; feeds tcw_queue.
module tcw_front (
   tcw_req_if.sink            req_bus,
   input  logic               accept_enable,
   input  logic               queue_full,
   output tcw_pkg::push_type  push_out
);

   tcw_pkg::row_type row_sat;
   tcw_pkg::col_type col_sat;

   // A request is taken when the queue has room and the store is not being initialized.
   assign req_bus.ready = accept_enable && !queue_full;

   // Saturate the target cell to the last row and column.
   always_comb begin
      if (int'(req_bus.target_row) > tcw_pkg::ROWS - 1) begin
         row_sat = tcw_pkg::row_type'(tcw_pkg::ROWS - 1);
      end else begin
         row_sat = tcw_pkg::row_type'(req_bus.target_row);
      end
      if (int'(req_bus.target_col) > tcw_pkg::COLUMNS - 1) begin
         col_sat = tcw_pkg::col_type'(tcw_pkg::COLUMNS - 1);
      end else begin
         col_sat = tcw_pkg::col_type'(req_bus.target_col);
      end
   end

   // Build the command for the queue.
   always_comb begin
      push_out.push        = req_bus.valid && req_bus.ready;
      push_out.cmd.action  = req_bus.action;
      push_out.cmd.newline = (req_bus.char_code == tcw_pkg::NEWLINE_CODE);
      push_out.cmd.code    = req_bus.char_code;
      push_out.cmd.color   = req_bus.char_color;
      push_out.cmd.row     = row_sat;
      push_out.cmd.col     = col_sat;
   end

endmodule

// ===== sv/tcw_queue.sv =====
// Short command queue that decouples the front from the back of the console.
// Depends on tcw_pkg.
module tcw_queue (
   input  logic               clock,
   input  logic               reset,
   input  tcw_pkg::push_type  push_in,
   output logic               full,
   output tcw_pkg::head_type  head,
   input  logic               pop
);

   localparam int PTR_W = $clog2(tcw_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(tcw_pkg::QUEUE_DEPTH + 1);

   tcw_pkg::cmd_type entry_ff [tcw_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(tcw_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push_in.push && !full;
   assign do_pop     = pop && head.valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_in.cmd;
      end
   end

endmodule

// ===== sv/tcw_back.sv =====
// Back of the console: cursor, ring of rows over the cell store, sweeps and responses.
// Depends on tcw_pkg, tcw_rsp_if and tcw_ram; takes commands from tcw_queue.
module tcw_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [tcw_pkg::COLOR_W-1:0]    blank_attr,
   input  tcw_pkg::head_type              head,
   output logic                           pop,
   output logic                           init_busy,
   tcw_rsp_if.source                      rsp_bus
);

   localparam int SUM_W = tcw_pkg::ROW_W + 1;

   // Sequencer states.
   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_SWEEP = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]         state_ff, state_in;
   tcw_pkg::cmd_type   cmd_ff, cmd_in;
   tcw_pkg::row_type   row_ff, row_in;
   tcw_pkg::col_type   col_ff, col_in;
   tcw_pkg::row_type   top_ff, top_in;
   tcw_pkg::addr_type  addr_ff, addr_in;
   tcw_pkg::addr_type  end_ff, end_in;
   tcw_pkg::cell_type  fill_ff, fill_in;
   tcw_pkg::cell_type  cell_ff, cell_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::POS_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic [tcw_pkg::TROW_W-1:0]    rsp_row_ff, rsp_row_in;
   logic [tcw_pkg::TCOL_W-1:0]    rsp_col_ff, rsp_col_in;
   tcw_pkg::cell_type             rsp_cell_ff, rsp_cell_in;

   logic               wr_en, rd_en;
   tcw_pkg::addr_type  wr_addr, rd_addr;
   tcw_pkg::cell_type  wr_data, rd_data;
   logic               advance;

   // Physical row of a screen row: the ring starts at the top row pointer.
   function automatic tcw_pkg::row_type phys_row(tcw_pkg::row_type r, tcw_pkg::row_type t);
      logic [SUM_W-1:0] sum;
      sum = {1'b0, r} + {1'b0, t};
      if (sum >= SUM_W'(tcw_pkg::ROWS)) begin
         sum = sum - SUM_W'(tcw_pkg::ROWS);
      end
      return sum[tcw_pkg::ROW_W-1:0];
   endfunction

   // Store address of a physical row and a column.
   function automatic tcw_pkg::addr_type cell_addr(tcw_pkg::row_type pr, tcw_pkg::col_type c);
      return tcw_pkg::addr_type'(int'(pr) * tcw_pkg::COLUMNS + int'(c));
   endfunction

   tcw_ram #(
      .WIDTH (tcw_pkg::CELL_W),
      .DEPTH (tcw_pkg::CELL_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign init_busy = (state_ff == ST_INIT);
   assign advance   = cmd_ff.newline || (col_ff == tcw_pkg::col_type'(tcw_pkg::COLUMNS - 1));

   // Sequencer: one command at a time, sweeps walk the store one cell a cycle.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      top_in       = top_ff;
      addr_in      = addr_ff;
      end_in       = end_ff;
      fill_in      = fill_ff;
      cell_in      = cell_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_cell_in  = rsp_cell_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = fill_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;

      unique case (state_ff)
         // Blank the whole store with the reset attribute after reset.
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_data = {tcw_pkg::BLANK_ATTR_RESET, tcw_pkg::SPACE_CODE};
            if (addr_ff == tcw_pkg::addr_type'(tcw_pkg::CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + tcw_pkg::addr_type'(1);
            end
         end

         ST_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               cmd_in   = head.cmd;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            cell_in = '0;
            unique case (cmd_ff.action)
               tcw_pkg::ACT_PUT: begin
                  if (!cmd_ff.newline) begin
                     wr_en   = 1'b1;
                     wr_addr = cell_addr(phys_row(row_ff, top_ff), col_ff);
                     wr_data = {cmd_ff.color, cmd_ff.code};
                  end
                  state_in = ST_DONE;
                  if (advance) begin
                     col_in = '0;
                     if (row_ff == tcw_pkg::row_type'(tcw_pkg::ROWS - 1)) begin
                        // Scroll: the old top row becomes the blank bottom row.
                        top_in   = (top_ff == tcw_pkg::row_type'(tcw_pkg::ROWS - 1))
                                   ? '0 : top_ff + tcw_pkg::row_type'(1);
                        addr_in  = cell_addr(top_ff, '0);
                        end_in   = cell_addr(top_ff,
                                             tcw_pkg::col_type'(tcw_pkg::COLUMNS - 1));
                        fill_in  = {blank_attr, tcw_pkg::SPACE_CODE};
                        state_in = ST_SWEEP;
                     end else begin
                        row_in = row_ff + tcw_pkg::row_type'(1);
                     end
                  end else begin
                     col_in = col_ff + tcw_pkg::col_type'(1);
                  end
               end
               tcw_pkg::ACT_CLEAR: begin
                  row_in   = '0;
                  col_in   = '0;
                  top_in   = '0;
                  addr_in  = '0;
                  end_in   = tcw_pkg::addr_type'(tcw_pkg::CELL_COUNT - 1);
                  fill_in  = {blank_attr, tcw_pkg::SPACE_CODE};
                  state_in = ST_SWEEP;
               end
               tcw_pkg::ACT_READ: begin
                  rd_en    = 1'b1;
                  rd_addr  = cell_addr(phys_row(cmd_ff.row, top_ff), cmd_ff.col);
                  state_in = ST_READ;
               end
               tcw_pkg::ACT_SET: begin
                  row_in   = cmd_ff.row;
                  col_in   = cmd_ff.col;
                  state_in = ST_DONE;
               end
            endcase
         end

         // Read data arrives in the cycle after the address.
         ST_READ: begin
            cell_in  = rd_data;
            state_in = ST_DONE;
         end

         // Blank a row for a scroll, or the whole store for a clear.
         ST_SWEEP: begin
            wr_en = 1'b1;
            if (addr_ff == end_ff) begin
               state_in = ST_DONE;
            end else begin
               addr_in = addr_ff + tcw_pkg::addr_type'(1);
            end
         end

         // Load the response register once it is free or being taken.
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = tcw_pkg::POS_W'(int'(row_ff) * tcw_pkg::COLUMNS + int'(col_ff));
               rsp_row_in   = tcw_pkg::TROW_W'(row_ff);
               rsp_col_in   = tcw_pkg::TCOL_W'(col_ff);
               rsp_cell_in  = cell_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         row_ff       <= '0;
         col_ff       <= '0;
         top_ff       <= '0;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         top_ff       <= top_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      end_ff      <= end_in;
      fill_ff     <= fill_in;
      cell_ff     <= cell_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_cell_ff <= rsp_cell_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.cursor_position = rsp_pos_ff;
   assign rsp_bus.cursor_row      = rsp_row_ff;
   assign rsp_bus.cursor_col      = rsp_col_ff;
   assign rsp_bus.cell_value      = rsp_cell_ff;

endmodule

// ===== sv/tcw_checker.sv =====
// Port-level checker for the text console writer, bound to the top level.
// Depends on tcw_pkg and the assertion macros header.
`include "text_console_writer_unit_assert.svh"

module tcw_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [tcw_pkg::POS_W-1:0]   rsp_cursor_position,
   input logic [tcw_pkg::TROW_W-1:0]  rsp_cursor_row,
   input logic [tcw_pkg::TCOL_W-1:0]  rsp_cursor_col,
   input logic [tcw_pkg::CELL_W-1:0]  rsp_cell_value
);

   logic [3:0] outstanding_ff, outstanding_in;
   logic       req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // Requests accepted whose responses are not yet taken.
   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_take && !rsp_take) begin
         outstanding_in = outstanding_ff + 4'd1;
      end else if (rsp_take && !req_take) begin
         outstanding_in = outstanding_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // A stalled response keeps its contents.
   `TCW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_cursor_position) && $stable(rsp_cursor_row) && $stable(rsp_cursor_col) && $stable(rsp_cell_value))

   // The cursor reported always lies on the screen.
   `TCW_ASSERT_SAME(a_cursor_range, clock, reset, rsp_valid, (int'(rsp_cursor_row) < tcw_pkg::ROWS) && (int'(rsp_cursor_col) < tcw_pkg::COLUMNS))

   // No response appears without a request waiting for it.
   `TCW_ASSERT_SAME(a_no_extra_rsp, clock, reset, rsp_valid, outstanding_ff != 4'd0)

   // Right after reset the store is being blanked: nothing taken, nothing offered.
   `TCW_ASSERT_SAME(a_reset_quiet, clock, reset, $past(reset), !req_ready && !rsp_valid)

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_bus.valid),
   .req_ready           (req_bus.ready),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_cursor_position (rsp_bus.cursor_position),
   .rsp_cursor_row      (rsp_bus.cursor_row),
   .rsp_cursor_col      (rsp_bus.cursor_col),
   .rsp_cell_value      (rsp_bus.cell_value)
);
